/* design/dhcm_pkg.sv */
// Shared types, constants and helpers of the detector hit channel mapper.
package dhcm_pkg;

    localparam int DEF_MAX_BOARDS        = 16;
    localparam int DEF_MAP_DEPTH         = 1024;
    localparam int DEF_MAX_HITS_PER_KIND = 64;

    localparam int ACTION_W  = 2;
    localparam int SERIAL_W  = 16;
    localparam int CHAN_W    = 6;
    localparam int ENERGY_W  = 16;
    localparam int TIME_W    = 48;
    localparam int TIDX_W    = 10;
    localparam int TVAL_W    = 16;
    localparam int CFG_W     = 5;
    localparam int KIND_W    = 2;
    localparam int DET_W     = 7;
    localparam int SLOT_W    = 6;
    localparam int COUNT_W   = 7;
    localparam int OFF_W     = 14;

    localparam int SERIAL_SPLIT   = 1000;
    localparam int WIDE_STRIDE    = 64;
    localparam int NARROW_BASE    = 7 * 64;
    localparam int NARROW_SKIP    = 7;
    localparam int NARROW_STRIDE  = 16;
    localparam int NARROW_ORG     = NARROW_BASE - NARROW_SKIP * NARROW_STRIDE;

    localparam logic [TVAL_W-1:0] ID_UNMAPPED = 16'hFFFF;
    localparam logic [TVAL_W-1:0] ID_QQQ_BASE = 16'd10000;
    localparam logic [TVAL_W-1:0] ID_PC_BASE  = 16'd20000;
    localparam logic [TVAL_W-1:0] ID_LIMIT    = 16'd30000;

    // x / 100 == (x * 5243) >> 19 for every x below 43699
    localparam int DIV_ID      = 100;
    localparam int RECIP       = 5243;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = OFF_W + RECIP_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_HIT      = 2'd0,
        ACT_EOE      = 2'd1,
        ACT_BOARD_WR = 2'd2,
        ACT_MAP_WR   = 2'd3
    } action_t;

    localparam logic [KIND_W-1:0] KIND_SX3 = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QQQ = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PC  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SUM = 2'd3;

    typedef struct packed {
        logic              en;
        logic [TIDX_W-1:0] idx;
        logic [TVAL_W-1:0] data;
    } board_wr_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [DET_W-1:0]    detector_id;
        logic [DET_W-1:0]    detector_channel;
        logic [ENERGY_W-1:0] hit_energy;
        logic [TIME_W-1:0]   hit_time;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  count_sx3;
        logic [COUNT_W-1:0]  count_qqq;
        logic [COUNT_W-1:0]  count_pc;
        logic                overflow;
    } res_t;

    function automatic int gch_width(input int max_boards);
        return $clog2(max_boards * WIDE_STRIDE + NARROW_ORG + WIDE_STRIDE);
    endfunction

endpackage

/* design/dhcm_in_if.sv */
// Input item channel of the detector hit channel mapper.
interface dhcm_in_if;
    import dhcm_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [SERIAL_W-1:0] board_serial;
    logic [CHAN_W-1:0]   channel;
    logic [ENERGY_W-1:0] energy;
    logic [TIME_W-1:0]   timestamp;
    logic [TIDX_W-1:0]   table_index;
    logic [TVAL_W-1:0]   table_value;

    modport source (
        output valid, action, board_serial, channel, energy, timestamp,
               table_index, table_value,
        input  ready
    );

    modport sink (
        input  valid, action, board_serial, channel, energy, timestamp,
               table_index, table_value,
        output ready
    );
endinterface

/* design/dhcm_out_if.sv */
// Result item channel of the detector hit channel mapper.
interface dhcm_out_if;
    import dhcm_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [DET_W-1:0]    detector_id;
    logic [DET_W-1:0]    detector_channel;
    logic [ENERGY_W-1:0] hit_energy;
    logic [TIME_W-1:0]   hit_time;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  count_sx3;
    logic [COUNT_W-1:0]  count_qqq;
    logic [COUNT_W-1:0]  count_pc;
    logic                overflow;

    modport source (
        output valid, kind, detector_id, detector_channel, hit_energy, hit_time,
               slot, count_sx3, count_qqq, count_pc, overflow,
        input  ready
    );

    modport sink (
        input  valid, kind, detector_id, detector_channel, hit_energy, hit_time,
               slot, count_sx3, count_qqq, count_pc, overflow,
        output ready
    );
endinterface

/* design/dhcm_board_lookup.sv */
// Board serial table with parallel match and global channel computation.
module dhcm_board_lookup #(
    parameter int MAX_BOARDS = dhcm_pkg::DEF_MAX_BOARDS
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  dhcm_pkg::board_wr_t                         wr,
    input  logic [dhcm_pkg::CFG_W-1:0]                  board_count,
    input  logic [dhcm_pkg::SERIAL_W-1:0]               serial,
    input  logic [dhcm_pkg::CHAN_W-1:0]                 channel,
    output logic [dhcm_pkg::gch_width(MAX_BOARDS)-1:0]  gch
);
    import dhcm_pkg::*;

    localparam int GCH_W  = gch_width(MAX_BOARDS);
    localparam int BIDX_W = (MAX_BOARDS > 1) ? $clog2(MAX_BOARDS) : 1;

    logic [SERIAL_W-1:0] serial_reg [MAX_BOARDS];
    logic [MAX_BOARDS-1:0] hit_vec;
    logic                  found;
    logic [BIDX_W-1:0]     match_idx;
    logic [GCH_W-1:0]      offset;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_BOARDS; j++)
            begin
                serial_reg[j] <= '0;
            end
        end
        else
        begin
            for (int j = 0; j < MAX_BOARDS; j++)
            begin
                if (wr.en && wr.idx == TIDX_W'(j))
                begin
                    serial_reg[j] <= wr.data;
                end
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < MAX_BOARDS; j++)
        begin
            hit_vec[j] = (serial_reg[j] == serial) && (32'(board_count) > j);
        end
    end

    // lowest matching index wins
    always_comb
    begin
        found     = 1'b0;
        match_idx = '0;
        for (int j = MAX_BOARDS - 1; j >= 0; j--)
        begin
            if (hit_vec[j])
            begin
                found     = 1'b1;
                match_idx = BIDX_W'(j);
            end
        end
    end

    always_comb
    begin
        if (32'(serial) > SERIAL_SPLIT)
        begin
            offset = GCH_W'(32'(match_idx) * WIDE_STRIDE);
        end
        else
        begin
            offset = GCH_W'(NARROW_ORG + 32'(match_idx) * NARROW_STRIDE);
        end
        gch = GCH_W'(channel) + (found ? offset : '0);
    end

endmodule

/* design/detector_hit_channel_mapper.sv */
// Top level of the detector hit channel mapper.
// One item is taken per clock cycle while the output does not stall; a hit
// result passes the stage 1, stage 2 and stage 3 registers into the output
// register. The rate is set by the single read port of the channel map
// memory, read once at acceptance, and the board serial compare, done across
// all table entries in parallel. After reset the channel map is swept to
// unmapped, one entry per cycle over all MAP_DEPTH entries; no item is
// accepted meanwhile. Writes, unmapped hits and dropped hits produce no result.
module detector_hit_channel_mapper #(
    parameter int MAX_BOARDS        = dhcm_pkg::DEF_MAX_BOARDS,
    parameter int MAP_DEPTH         = dhcm_pkg::DEF_MAP_DEPTH,
    parameter int MAX_HITS_PER_KIND = dhcm_pkg::DEF_MAX_HITS_PER_KIND
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [dhcm_pkg::CFG_W-1:0] cfg_wr_data,
    dhcm_in_if.sink                    hit_in,
    dhcm_out_if.source                 result_out
);
    import dhcm_pkg::*;

    localparam int AW    = $clog2(MAP_DEPTH);
    localparam int CW    = $clog2(MAX_HITS_PER_KIND + 1);
    localparam int GCH_W = gch_width(MAX_BOARDS);

    logic [CFG_W-1:0] board_count_reg;

    logic          acc;
    action_t       act;
    board_wr_t     bwr;
    logic [GCH_W-1:0] gch;
    logic [31:0]   gch_ext;
    logic [31:0]   tidx_ext;

    // map memory
    logic [TVAL_W-1:0] map_mem [MAP_DEPTH];
    logic [TVAL_W-1:0] map_rd_reg;
    logic              map_we;
    logic              map_re;
    logic [AW-1:0]     map_wa;
    logic [TVAL_W-1:0] map_wd;
    logic              clearing_reg;
    logic [AW-1:0]     clr_addr_reg;

    // pipeline control
    logic load1;
    logic load2;
    logic load3;
    logic out_load;
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic out_v_reg;

    // stage 1
    logic                s1_eoe_reg;
    logic                s1_inmap_reg;
    logic [ENERGY_W-1:0] s1_energy_reg;
    logic [TIME_W-1:0]   s1_time_reg;

    logic [TVAL_W-1:0] s1_id;
    logic              s1_valid_id;
    logic [KIND_W-1:0] s1_kind;
    logic [OFF_W-1:0]  s1_id_off;
    logic [CW-1:0]     s1_cnt;
    logic              s1_full;
    logic              s1_emit;
    res_t              s1_res;
    logic [OFF_W-1:0]  s1_off;
    logic [31:0]       cnt_w;
    logic [31:0]       sx3_w;
    logic [31:0]       qqq_w;
    logic [31:0]       pc_w;

    logic [CW-1:0] sx3_cnt_reg;
    logic [CW-1:0] qqq_cnt_reg;
    logic [CW-1:0] pc_cnt_reg;
    logic          dropped_reg;

    // stages 2, 3, output
    res_t             s2_res_reg;
    logic [OFF_W-1:0] s2_off_reg;
    res_t             s3_res_reg;
    res_t             s3_res_next;
    logic [OFF_W-1:0] s3_off_reg;
    res_t             out_res_reg;
    res_t             out_res_next;
    logic [PROD_W-1:0] prod;
    logic [OFF_W-1:0]  rem;

    assign acc = hit_in.valid && hit_in.ready;
    assign act = action_t'(hit_in.action);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            board_count_reg <= cfg_wr_data;
        end
    end

    assign bwr.en   = acc && (act == ACT_BOARD_WR);
    assign bwr.idx  = hit_in.table_index;
    assign bwr.data = hit_in.table_value;

    dhcm_board_lookup #(
        .MAX_BOARDS (MAX_BOARDS)
    ) u_board_lookup (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (bwr),
        .board_count (board_count_reg),
        .serial      (hit_in.board_serial),
        .channel     (hit_in.channel),
        .gch         (gch)
    );

    assign gch_ext  = 32'(gch);
    assign tidx_ext = 32'(hit_in.table_index);

    // clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(MAP_DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        map_re = acc && (act == ACT_HIT);
        if (clearing_reg)
        begin
            map_we = 1'b1;
            map_wa = clr_addr_reg;
            map_wd = ID_UNMAPPED;
        end
        else
        begin
            map_we = acc && (act == ACT_MAP_WR) && (tidx_ext < MAP_DEPTH);
            map_wa = tidx_ext[AW-1:0];
            map_wd = hit_in.table_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_wa] <= map_wd;
        end
        if (map_re)
        begin
            map_rd_reg <= map_mem[gch_ext[AW-1:0]];
        end
    end

    // handshake chain
    assign out_load     = !out_v_reg || result_out.ready;
    assign load3        = !v3_reg || out_load;
    assign load2        = !v2_reg || load3;
    assign load1        = !v1_reg || load2;
    assign hit_in.ready = load1 && !clearing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (load1)
            begin
                v1_reg <= acc && (act == ACT_HIT || act == ACT_EOE);
            end
            if (load2)
            begin
                v2_reg <= v1_reg && s1_emit;
            end
            if (load3)
            begin
                v3_reg <= v2_reg;
            end
            if (out_load)
            begin
                out_v_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1 && acc)
        begin
            s1_eoe_reg    <= (act == ACT_EOE);
            s1_inmap_reg  <= (gch_ext < MAP_DEPTH);
            s1_energy_reg <= hit_in.energy;
            s1_time_reg   <= hit_in.timestamp;
        end
    end

    // stage 1: classify, check list, build result
    always_comb
    begin
        s1_id       = s1_inmap_reg ? map_rd_reg : ID_UNMAPPED;
        s1_valid_id = s1_id < ID_LIMIT;
        if (s1_id < ID_QQQ_BASE)
        begin
            s1_kind   = KIND_SX3;
            s1_id_off = OFF_W'(s1_id);
            s1_cnt    = sx3_cnt_reg;
        end
        else if (s1_id < ID_PC_BASE)
        begin
            s1_kind   = KIND_QQQ;
            s1_id_off = OFF_W'(s1_id - ID_QQQ_BASE);
            s1_cnt    = qqq_cnt_reg;
        end
        else
        begin
            s1_kind   = KIND_PC;
            s1_id_off = OFF_W'(s1_id - ID_PC_BASE);
            s1_cnt    = pc_cnt_reg;
        end
        s1_full = (s1_cnt == CW'(MAX_HITS_PER_KIND));
        s1_emit = s1_eoe_reg || (s1_valid_id && !s1_full);

        cnt_w = 32'(s1_cnt);
        sx3_w = 32'(sx3_cnt_reg);
        qqq_w = 32'(qqq_cnt_reg);
        pc_w  = 32'(pc_cnt_reg);

        s1_res = '0;
        s1_off = '0;
        if (s1_eoe_reg)
        begin
            s1_res.kind      = KIND_SUM;
            s1_res.count_sx3 = sx3_w[COUNT_W-1:0];
            s1_res.count_qqq = qqq_w[COUNT_W-1:0];
            s1_res.count_pc  = pc_w[COUNT_W-1:0];
            s1_res.overflow  = dropped_reg;
        end
        else
        begin
            s1_res.kind       = s1_kind;
            s1_res.hit_energy = s1_energy_reg;
            s1_res.hit_time   = s1_time_reg;
            s1_res.slot       = cnt_w[SLOT_W-1:0];
            s1_off            = s1_id_off;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx3_cnt_reg <= '0;
            qqq_cnt_reg <= '0;
            pc_cnt_reg  <= '0;
            dropped_reg <= 1'b0;
        end
        else if (v1_reg && load2)
        begin
            if (s1_eoe_reg)
            begin
                sx3_cnt_reg <= '0;
                qqq_cnt_reg <= '0;
                pc_cnt_reg  <= '0;
                dropped_reg <= 1'b0;
            end
            else if (s1_valid_id)
            begin
                if (s1_full)
                begin
                    dropped_reg <= 1'b1;
                end
                else
                begin
                    unique case (s1_kind)
                        KIND_SX3: sx3_cnt_reg <= sx3_cnt_reg + 1'b1;
                        KIND_QQQ: qqq_cnt_reg <= qqq_cnt_reg + 1'b1;
                        default:  pc_cnt_reg  <= pc_cnt_reg + 1'b1;
                    endcase
                end
            end
        end
    end

    // stage 2 -> 3: quotient by reciprocal; stage 3 -> out: remainder
    assign prod = PROD_W'(s2_off_reg) * PROD_W'(RECIP);
    assign rem  = s3_off_reg - OFF_W'(s3_res_reg.detector_id) * OFF_W'(DIV_ID);

    always_comb
    begin
        s3_res_next                   = s2_res_reg;
        s3_res_next.detector_id       = prod[RECIP_SHIFT+DET_W-1:RECIP_SHIFT];
        out_res_next                  = s3_res_reg;
        out_res_next.detector_channel = rem[DET_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            s2_res_reg <= s1_res;
            s2_off_reg <= s1_off;
        end
        if (load3)
        begin
            s3_res_reg <= s3_res_next;
            s3_off_reg <= s2_off_reg;
        end
        if (out_load)
        begin
            out_res_reg <= out_res_next;
        end
    end

    assign result_out.valid            = out_v_reg;
    assign result_out.kind             = out_res_reg.kind;
    assign result_out.detector_id      = out_res_reg.detector_id;
    assign result_out.detector_channel = out_res_reg.detector_channel;
    assign result_out.hit_energy       = out_res_reg.hit_energy;
    assign result_out.hit_time         = out_res_reg.hit_time;
    assign result_out.slot             = out_res_reg.slot;
    assign result_out.count_sx3        = out_res_reg.count_sx3;
    assign result_out.count_qqq        = out_res_reg.count_qqq;
    assign result_out.count_pc         = out_res_reg.count_pc;
    assign result_out.overflow         = out_res_reg.overflow;

endmodule

/* design/dhcm_checker.sv */
// Port-level assertions for the detector hit channel mapper, with bind.
module dhcm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [dhcm_pkg::KIND_W-1:0]   out_kind,
    input logic [dhcm_pkg::DET_W-1:0]    out_detector_id,
    input logic [dhcm_pkg::DET_W-1:0]    out_detector_channel,
    input logic [dhcm_pkg::ENERGY_W-1:0] out_hit_energy,
    input logic [dhcm_pkg::TIME_W-1:0]   out_hit_time,
    input logic [dhcm_pkg::SLOT_W-1:0]   out_slot,
    input logic [dhcm_pkg::COUNT_W-1:0]  out_count_sx3,
    input logic [dhcm_pkg::COUNT_W-1:0]  out_count_qqq,
    input logic [dhcm_pkg::COUNT_W-1:0]  out_count_pc,
    input logic                          out_overflow
);
    import dhcm_pkg::*;

    localparam int DET_MAX = 100;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_hit_no_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind != KIND_SUM |->
            out_count_sx3 == '0 && out_count_qqq == '0 && out_count_pc == '0
            && !out_overflow)
        else $error("hit item carries summary fields");

    a_sum_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == KIND_SUM |->
            out_detector_id == '0 && out_detector_channel == '0
            && out_hit_energy == '0 && out_hit_time == '0 && out_slot == '0)
        else $error("summary item carries hit fields");

    a_split_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind != KIND_SUM |->
            32'(out_detector_id) < DET_MAX && 32'(out_detector_channel) < DET_MAX)
        else $error("detector id split out of range");

endmodule

bind detector_hit_channel_mapper dhcm_checker u_dhcm_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .out_valid            (result_out.valid),
    .out_ready            (result_out.ready),
    .out_kind             (result_out.kind),
    .out_detector_id      (result_out.detector_id),
    .out_detector_channel (result_out.detector_channel),
    .out_hit_energy       (result_out.hit_energy),
    .out_hit_time         (result_out.hit_time),
    .out_slot             (result_out.slot),
    .out_count_sx3        (result_out.count_sx3),
    .out_count_qqq        (result_out.count_qqq),
    .out_count_pc         (result_out.count_pc),
    .out_overflow         (result_out.overflow)
);
